FILE: design/gate_structural_dedup_top_assert.svh
// assertion macros for the gate dedup block
// both sample on the rising edge of clock and are off while reset is high
`ifndef GATE_STRUCTURAL_DEDUP_TOP_ASSERT_SVH
`define GATE_STRUCTURAL_DEDUP_TOP_ASSERT_SVH

// condition holds at every edge
`define GSD_ASSERT_HOLD(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent at one edge forces consequent at the next
`define GSD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/gsd_pkg.sv
package gsd_pkg;

   localparam int WIRE_W  = 16;
   localparam int WIRE_SPAN = 1 << WIRE_W;
   localparam int EPOCH_W = 4;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

   // quotient of the bucket reduction stays below 2**MOD_STEPS
   localparam int MOD_STEPS = 7;

   localparam int TABLE_DEPTH_DEF = 65536;
   localparam int MAX_WIRES_DEF   = 65536;
   localparam int PROBE_LIMIT_DEF = 10;

   typedef struct packed {
      logic [WIRE_W-1:0] left;
      logic [WIRE_W-1:0] right;
      logic              kind;
      logic [WIRE_W-1:0] output_wire;
   } key_slot_type;

   typedef struct packed {
      logic [EPOCH_W-1:0] tag;
      key_slot_type       slot;
   } key_entry_type;

   typedef struct packed {
      logic [EPOCH_W-1:0] tag;
      logic [WIRE_W-1:0]  wire_id;
   } remap_entry_type;

endpackage

FILE: design/gate_structural_dedup_top.sv
// gate structural dedup: structural hashing of a gate stream
// input: a gate beat is taken when start is high and busy is low; req_* carry
//    the two input wires, the gate kind, the driven wire and the last-gate flag
// output: one result beat per gate, rsp_strobe high for exactly one cycle with
//    rsp_* valid; the receiver cannot stall, so nothing waits on it
// sequence: an accepted gate passes ORDER, HASH and PROBE, which makes one probe per slot
//    probed (1 to PROBE_LIMIT), then a registered strobe; busy drops together with the strobe,
//    so a new gate is taken only after the result of the last one
// the probe rate is set by the key table memory: one probe per cycle, each probe
//    needs the registered read of the previous slot
// both tables carry an epoch tag; an entry whose tag is not the current epoch
//    reads as its reset value (identity wire, empty slot)
// a last gate bumps the epoch, so the tables look cleared to the next gate
// after reset, and after every 15th circuit when the epoch wraps, a clearing
//    pass over max(remap depth, TABLE_DEPTH) entries (65536 by default) runs
//    with busy high
`include "gate_structural_dedup_top_assert.svh"

module gate_structural_dedup_top #(
   parameter int TABLE_DEPTH = gsd_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_WIRES   = gsd_pkg::MAX_WIRES_DEF,
   parameter int PROBE_LIMIT = gsd_pkg::PROBE_LIMIT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [gsd_pkg::WIRE_W-1:0] req_left_wire,
   input  logic [gsd_pkg::WIRE_W-1:0] req_right_wire,
   input  logic                      req_gate_kind,
   input  logic [gsd_pkg::WIRE_W-1:0] req_out_wire,
   input  logic                      req_last_gate,
   output logic                      rsp_strobe,
   output logic                      rsp_keep,
   output logic [gsd_pkg::WIRE_W-1:0] rsp_left_out,
   output logic [gsd_pkg::WIRE_W-1:0] rsp_right_out,
   output logic                      rsp_kind_out,
   output logic [gsd_pkg::WIRE_W-1:0] rsp_out_wire_out
);
   import gsd_pkg::*;

   localparam int REMAP_DEPTH = (MAX_WIRES < WIRE_SPAN) ? MAX_WIRES : WIRE_SPAN;
   localparam int RAW = $clog2(REMAP_DEPTH);
   localparam int TW  = $clog2(TABLE_DEPTH);
   localparam int CLEAR_DEPTH = (REMAP_DEPTH > TABLE_DEPTH) ? REMAP_DEPTH : TABLE_DEPTH;
   localparam int CW  = $clog2(CLEAR_DEPTH);
   localparam int PCW = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ORDER = 3'd1;
   localparam logic [2:0] ST_HASH  = 3'd2;
   localparam logic [2:0] ST_PROBE = 3'd3;
   localparam logic [2:0] ST_CLEAR = 3'd4;

   // memories
   remap_entry_type remap_mem [REMAP_DEPTH];
   key_entry_type   key_mem   [TABLE_DEPTH];

   // control registers
   logic [2:0]         state_ff, state_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [CW-1:0]      clr_ff, clr_in;
   logic               rsp_strobe_ff, rsp_strobe_in;

   // payload registers
   logic [WIRE_W-1:0]  lw_ff, rw_ff, ow_ff;
   logic               kind_ff, last_ff;
   logic               lw_rng_ff, rw_rng_ff, ow_rng_ff;
   logic [WIRE_W-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [TW-1:0]      idx_ff, idx_in;
   logic [PCW-1:0]     cnt_ff, cnt_in;
   logic               keep_ff, keep_in;
   logic [WIRE_W-1:0]  left_out_ff, right_out_ff, ow_out_ff;
   logic               kind_out_ff;
   remap_entry_type    rda_ff, rdb_ff;
   key_entry_type      key_rd_ff;

   // memory controls
   logic               rmap_re, rmap_we;
   logic [RAW-1:0]     rmap_wa;
   remap_entry_type    rmap_wd;
   logic               key_re, key_we;
   logic [TW-1:0]      key_ra, key_wa;
   key_entry_type      key_wd;

   logic               done;
   logic [WIRE_W-1:0]  wire_a, wire_b;
   logic [31:0]        rem_v;
   logic [TW-1:0]      bucket;
   logic [TW:0]        idx_inc;
   logic [TW-1:0]      idx_next;
   logic               slot_empty, slot_match;

   // remapped pair and ordering
   always_comb begin
      wire_a = (lw_rng_ff && rda_ff.tag == epoch_ff) ? rda_ff.wire_id : lw_ff;
      wire_b = (rw_rng_ff && rdb_ff.tag == epoch_ff) ? rdb_ff.wire_id : rw_ff;
      lo_in  = (wire_a < wire_b) ? wire_a : wire_b;
      hi_in  = (wire_a < wire_b) ? wire_b : wire_a;
   end

   // bucket = {hi, kind} mod TABLE_DEPTH by restoring subtraction
   always_comb begin
      rem_v = 32'({hi_ff, kind_ff});
      for (int k = MOD_STEPS - 1; k >= 0; k--) begin
         if (rem_v >= (32'(TABLE_DEPTH) << k)) begin
            rem_v = rem_v - (32'(TABLE_DEPTH) << k);
         end
      end
      bucket = rem_v[TW-1:0];
   end

   always_comb begin
      idx_inc  = {1'b0, idx_ff} + (TW+1)'(1);
      idx_next = (idx_inc == (TW+1)'(TABLE_DEPTH)) ? '0 : idx_inc[TW-1:0];
   end

   // a stale tag reads as an empty slot
   assign slot_empty = (key_rd_ff.tag != epoch_ff) || (key_rd_ff.slot.output_wire == '0);
   assign slot_match = (key_rd_ff.slot.left == lo_ff) && (key_rd_ff.slot.right == hi_ff)
                       && (key_rd_ff.slot.kind == kind_ff);

   always_comb begin
      state_in      = state_ff;
      epoch_in      = epoch_ff;
      clr_in        = clr_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      keep_in       = keep_ff;
      rsp_strobe_in = 1'b0;
      done          = 1'b0;
      rmap_re       = 1'b0;
      rmap_we       = 1'b0;
      rmap_wa       = ow_ff[RAW-1:0];
      rmap_wd       = '{tag: epoch_ff, wire_id: key_rd_ff.slot.output_wire};
      key_re        = 1'b0;
      key_ra        = idx_ff;
      key_we        = 1'b0;
      key_wa        = idx_ff;
      key_wd        = '{tag: epoch_ff,
                        slot: '{left: lo_ff, right: hi_ff, kind: kind_ff, output_wire: ow_ff}};
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rmap_re  = 1'b1;
               state_in = ST_ORDER;
            end
         end
         ST_ORDER: begin
            state_in = ST_HASH;
         end
         ST_HASH: begin
            key_re   = 1'b1;
            key_ra   = bucket;
            idx_in   = bucket;
            cnt_in   = '0;
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            priority if (slot_empty) begin
               key_we  = 1'b1;
               keep_in = 1'b1;
               done    = 1'b1;
            end else if (slot_match) begin
               rmap_we = ow_rng_ff;
               keep_in = 1'b0;
               done    = 1'b1;
            end else if (cnt_ff == PCW'(PROBE_LIMIT - 1)) begin
               keep_in = 1'b1;
               done    = 1'b1;
            end else begin
               key_re = 1'b1;
               key_ra = idx_next;
               idx_in = idx_next;
               cnt_in = cnt_ff + PCW'(1);
            end
         end
         ST_CLEAR: begin
            rmap_we = ({1'b0, clr_ff} < (CW+1)'(REMAP_DEPTH));
            rmap_wa = clr_ff[RAW-1:0];
            rmap_wd = '{tag: '0, wire_id: WIRE_W'(clr_ff)};
            key_we  = ({1'b0, clr_ff} < (CW+1)'(TABLE_DEPTH));
            key_wa  = clr_ff[TW-1:0];
            key_wd  = '0;
            if (clr_ff == CW'(CLEAR_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + CW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (done) begin
         rsp_strobe_in = 1'b1;
         state_in      = ST_IDLE;
         // end of circuit: a new epoch hides every entry, a wrap needs a real sweep
         if (last_ff) begin
            if (epoch_ff == EPOCH_LAST) begin
               epoch_in = EPOCH_FIRST;
               clr_in   = '0;
               state_in = ST_CLEAR;
            end else begin
               epoch_in = epoch_ff + EPOCH_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         epoch_ff      <= EPOCH_FIRST;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         epoch_ff      <= epoch_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         lw_ff     <= req_left_wire;
         rw_ff     <= req_right_wire;
         kind_ff   <= req_gate_kind;
         ow_ff     <= req_out_wire;
         last_ff   <= req_last_gate;
         lw_rng_ff <= ({1'b0, req_left_wire} < (WIRE_W+1)'(REMAP_DEPTH));
         rw_rng_ff <= ({1'b0, req_right_wire} < (WIRE_W+1)'(REMAP_DEPTH));
         ow_rng_ff <= ({1'b0, req_out_wire} < (WIRE_W+1)'(REMAP_DEPTH));
      end
      if (state_ff == ST_ORDER) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
      idx_ff  <= idx_in;
      cnt_ff  <= cnt_in;
      keep_ff <= keep_in;
      if (done) begin
         left_out_ff  <= lo_ff;
         right_out_ff <= hi_ff;
         kind_out_ff  <= kind_ff;
         ow_out_ff    <= ow_ff;
      end
   end

   // remap store, two read ports for the gate's input wires
   always_ff @(posedge clock) begin
      if (rmap_we) begin
         remap_mem[rmap_wa] <= rmap_wd;
      end
      if (rmap_re) begin
         rda_ff <= remap_mem[req_left_wire[RAW-1:0]];
         rdb_ff <= remap_mem[req_right_wire[RAW-1:0]];
      end
   end

   // key store, one probe read per cycle
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_wa] <= key_wd;
      end
      if (key_re) begin
         key_rd_ff <= key_mem[key_ra];
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_keep         = keep_ff;
   assign rsp_left_out     = left_out_ff;
   assign rsp_right_out    = right_out_ff;
   assign rsp_kind_out     = kind_out_ff;
   assign rsp_out_wire_out = ow_out_ff;

   `GSD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
   `GSD_ASSERT_NEXT(a_strobe_single, rsp_strobe, !rsp_strobe, "result strobe held two cycles")
   `GSD_ASSERT_HOLD(a_strobe_from_probe, !rsp_strobe || $past(state_ff) == ST_PROBE, "strobe without a probe")
   `GSD_ASSERT_HOLD(a_epoch_live, epoch_ff != '0, "current epoch equals the cleared tag")
   `GSD_ASSERT_HOLD(a_probe_bound, state_ff != ST_PROBE || cnt_ff <= PCW'(PROBE_LIMIT - 1), "probe count past limit")

endmodule

FILE: tb/sv/gate_structural_dedup_top_tb.sv
`timescale 1ns / 100ps

module gate_structural_dedup_top_tb;
   import gsd_pkg::*;

   localparam logic KIND_AND = 1'b0;
   localparam logic KIND_XOR = 1'b1;
   localparam int   GATE_COUNT = 1900;

   typedef struct {
      logic [WIRE_W-1:0] left_wire;
      logic [WIRE_W-1:0] right_wire;
      logic              kind;
      logic [WIRE_W-1:0] out_wire;
      logic              last;
   } gate_type;

   typedef struct {
      logic              keep;
      logic [WIRE_W-1:0] left_w;
      logic [WIRE_W-1:0] right_w;
      logic              kind;
      logic [WIRE_W-1:0] out_w;
   } dedup_result_type;

   class dedup_predictor;
      logic [WIRE_W-1:0] wire_alias[int];
      key_slot_type      key_slots[int];
      dedup_result_type  pending_results[$];
      int                mismatches = 0;

      task report_mismatch(string msg);
         $display("ERROR at %0t: %s", $time, msg);
         mismatches++;
      endtask

      function logic [WIRE_W-1:0] remapped(logic [WIRE_W-1:0] w);
         return wire_alias.exists(int'(w)) ? wire_alias[int'(w)] : w;
      endfunction

      // walks the key table exactly as the block should and queues the beat it owes
      function void note_gate(gate_type g);
         logic [WIRE_W-1:0] a, b, lo, hi;
         int                bucket, idx;
         bit                found;
         key_slot_type      s;
         dedup_result_type  e;
         a = remapped(g.left_wire);
         b = remapped(g.right_wire);
         lo = (a < b) ? a : b;
         hi = (a < b) ? b : a;
         bucket = ((int'(hi) << 1) | int'(g.kind)) % TABLE_DEPTH_DEF;
         found = 1'b0;
         for (int j = 0; j < PROBE_LIMIT_DEF; j++) begin
            idx = (bucket + j) % TABLE_DEPTH_DEF;
            s = key_slots.exists(idx) ? key_slots[idx] : '0;
            if (s.output_wire == '0) begin
               s.left = lo;
               s.right = hi;
               s.kind = g.kind;
               s.output_wire = g.out_wire;
               key_slots[idx] = s;
               break;
            end
            if (s.left == lo && s.right == hi && s.kind == g.kind) begin
               wire_alias[int'(g.out_wire)] = s.output_wire;
               found = 1'b1;
               break;
            end
         end
         e.keep = !found;
         e.left_w = lo;
         e.right_w = hi;
         e.kind = g.kind;
         e.out_w = g.out_wire;
         pending_results.push_back(e);
         // end of circuit: both tables back to reset contents
         if (g.last) begin
            wire_alias.delete();
            key_slots.delete();
         end
      endfunction

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
      endtask

      task check_result(dedup_result_type got);
         dedup_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("result beat with no gate outstanding");
            return;
         end
         want = pending_results.pop_front();
         compare_field("keep", 32'(got.keep), 32'(want.keep));
         compare_field("left_out", 32'(got.left_w), 32'(want.left_w));
         compare_field("right_out", 32'(got.right_w), 32'(want.right_w));
         compare_field("kind_out", 32'(got.kind), 32'(want.kind));
         compare_field("out_wire_out", 32'(got.out_w), 32'(want.out_w));
      endtask

      function int outstanding();
         return pending_results.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [WIRE_W-1:0] req_left_wire = '0;
   logic [WIRE_W-1:0] req_right_wire = '0;
   logic              req_gate_kind = 1'b0;
   logic [WIRE_W-1:0] req_out_wire = '0;
   logic              req_last_gate = 1'b0;
   logic              rsp_strobe;
   logic              rsp_keep;
   logic [WIRE_W-1:0] rsp_left_out;
   logic [WIRE_W-1:0] rsp_right_out;
   logic              rsp_kind_out;
   logic [WIRE_W-1:0] rsp_out_wire_out;

   dedup_predictor dedup;

   gate_structural_dedup_top u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_left_wire    (req_left_wire),
      .req_right_wire   (req_right_wire),
      .req_gate_kind    (req_gate_kind),
      .req_out_wire     (req_out_wire),
      .req_last_gate    (req_last_gate),
      .rsp_strobe       (rsp_strobe),
      .rsp_keep         (rsp_keep),
      .rsp_left_out     (rsp_left_out),
      .rsp_right_out    (rsp_right_out),
      .rsp_kind_out     (rsp_kind_out),
      .rsp_out_wire_out (rsp_out_wire_out)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      dedup_result_type got;
      if (!reset && rsp_strobe) begin
         got.keep = rsp_keep;
         got.left_w = rsp_left_out;
         got.right_w = rsp_right_out;
         got.kind = rsp_kind_out;
         got.out_w = rsp_out_wire_out;
         dedup.check_result(got);
      end
   end

   function automatic void add_gate(ref gate_type q[$], input logic [WIRE_W-1:0] l,
                                    input logic [WIRE_W-1:0] r, input logic k,
                                    input logic [WIRE_W-1:0] o, input logic last);
      gate_type g;
      g.left_wire = l;
      g.right_wire = r;
      g.kind = k;
      g.out_wire = o;
      g.last = last;
      q.push_back(g);
   endfunction

   function automatic void build_directed(ref gate_type q[$]);
      // output wire zero leaves the slot empty, so the next gate inserts there
      add_gate(q, 16'h0000, 16'h0000, KIND_AND, 16'h0000, 1'b0);
      add_gate(q, 16'h0000, 16'h0000, KIND_AND, 16'h0005, 1'b0);
      add_gate(q, 16'h0000, 16'h0000, KIND_AND, 16'h0006, 1'b0);
      add_gate(q, 16'h0006, 16'h0001, KIND_XOR, 16'h0007, 1'b0);
      // hit that remaps wire zero
      add_gate(q, 16'h0001, 16'h0005, KIND_XOR, 16'h0000, 1'b0);
      add_gate(q, 16'h0000, 16'h0002, KIND_AND, 16'h0008, 1'b0);
      // top bucket, then a probe that wraps to the bottom of the table
      add_gate(q, 16'hffff, 16'hffff, KIND_XOR, 16'hffff, 1'b0);
      add_gate(q, 16'h7fff, 16'h7fff, KIND_XOR, 16'h1234, 1'b0);
      add_gate(q, 16'h7fff, 16'h7fff, KIND_XOR, 16'h4321, 1'b0);
      // one bucket filled past the probe limit
      for (int i = 0; i < 11; i++)
         add_gate(q, 16'h0010 + 16'(i), 16'h0100, KIND_AND, 16'h0300 + 16'(i), 1'b0);
      add_gate(q, 16'h001a, 16'h0100, KIND_AND, 16'h0320, 1'b0);
      add_gate(q, 16'h0100, 16'h0013, KIND_AND, 16'h0321, 1'b1);
      // fresh circuit: earlier remaps and keys are gone
      add_gate(q, 16'h0006, 16'h0006, KIND_AND, 16'h0001, 1'b0);
      add_gate(q, 16'h0013, 16'h0100, KIND_AND, 16'h0022, 1'b1);
   endfunction

   // one circuit: small wire pools and repeated gates make duplicates common
   function automatic void build_circuit(ref gate_type q[$]);
      int                len, style, pool, roll;
      logic [WIRE_W-1:0] base, fresh, hi_c, tmp;
      logic              kind_c;
      gate_type          g;
      q.delete();
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(20, 60);
      style = $urandom_range(0, 9);
      pool = $urandom_range(2, 24);
      base = ($urandom_range(0, 7) == 0) ? '0 : 16'($urandom_range(0, 65000));
      fresh = base + 16'(pool);
      hi_c = 16'($urandom_range(64, 65535));
      kind_c = 1'($urandom_range(0, 1));
      for (int j = 0; j < len; j++) begin
         if (j > 0 && $urandom_range(0, 99) < 30) begin
            g = q[$urandom_range(0, q.size() - 1)];
         end else if (style <= 5) begin
            g.left_wire = base + 16'($urandom_range(0, int'(fresh - base) - 1));
            g.right_wire = base + 16'($urandom_range(0, int'(fresh - base) - 1));
            g.kind = 1'($urandom_range(0, 1));
         end else if (style <= 7) begin
            g.left_wire = hi_c - 16'($urandom_range(0, 40));
            g.right_wire = hi_c;
            g.kind = kind_c;
         end else begin
            g.left_wire = 16'($urandom);
            g.right_wire = 16'($urandom);
            g.kind = 1'($urandom_range(0, 1));
         end
         if ($urandom_range(0, 1) == 1) begin
            tmp = g.left_wire;
            g.left_wire = g.right_wire;
            g.right_wire = tmp;
         end
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            g.out_wire = '0;
         end else if (roll < 12) begin
            g.out_wire = 16'($urandom);
         end else begin
            g.out_wire = fresh;
            fresh++;
         end
         g.last = (j == len - 1);
         q.push_back(g);
      end
   endfunction

   task automatic send_gate(input gate_type g, input bit may_idle);
      int gap;
      if (may_idle && $urandom_range(0, 99) < 17) begin
         @(negedge clock);
         start <= 1'b0;
         gap = $urandom_range(1, 12);
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_left_wire <= g.left_wire;
      req_right_wire <= g.right_wire;
      req_gate_kind <= g.kind;
      req_out_wire <= g.out_wire;
      req_last_gate <= g.last;
      do @(posedge clock); while (busy);
      dedup.note_gate(g);
   endtask

   initial begin
      gate_type gates[$];
      int       sent;
      dedup = new();
      sent = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      build_directed(gates);
      foreach (gates[i])
         send_gate(gates[i], 1'b1);

      while (sent < GATE_COUNT) begin
         build_circuit(gates);
         foreach (gates[i]) begin
            // a long stretch of back-to-back beats in the middle of the run
            send_gate(gates[i], !(sent >= 600 && sent < 1000));
            sent++;
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (dedup.outstanding() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
      if (dedup.mismatches == 0)
         $display("gate_structural_dedup_top_tb OK");
      else
         $display("gate_structural_dedup_top_tb NOT OK");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("gate_structural_dedup_top_tb NOT OK");
      $finish;
   end

endmodule
